@@ rtl/hdlt_pkg.sv @@
`default_nettype none
package hdlt_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MS9,
        S_MS4,
        S_SOUP,
        S_MR,
        S_MC2,
        S_C2,
        S_MG,
        S_MC4,
        S_C4,
        S_MB,
        S_BLUE,
        S_OUT
    } t_state;

    localparam logic [23:0] DRAW_LIMIT   = 24'd83886;
    localparam logic [2:0]  SIZE_RESET   = 3'd4;
    localparam logic [2:0]  SIZE_MIN     = 3'd2;
    localparam logic [7:0]  RED_BASE     = 8'd155;
    localparam int          SUM_W        = 38;
    localparam logic        REG_SIZE     = 1'b0;

    // Read slots of one pixel: nine soup reads, four pot reads, one flame read.
    localparam logic [3:0]  K_POT_FIRST  = 4'd9;
    localparam logic [3:0]  K_FLAME      = 4'd13;
    localparam logic [3:0]  K_END        = 4'd14;

    function automatic logic signed [1:0] wobble(input logic [3:0] idx);
        logic signed [1:0] w;
        case (idx)
            4'd3, 4'd4, 4'd5:    w = 2'sd1;
            4'd11, 4'd12, 4'd13: w = -2'sd1;
            default:             w = 2'sd0;
        endcase
        return w;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > SUM_W'(64'sh7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -SUM_W'(64'sh8000_0000)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/hdlt_mem.sv @@
`default_nettype none
module hdlt_mem #(
    parameter int AW = 12,
    parameter int DW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [DW-1:0] i_wdata,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1<<AW)-1];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;

endmodule
`default_nettype wire

@@ rtl/hdlt_mul.sv @@
`default_nettype none
module hdlt_mul #(
    parameter int AW = 36,
    parameter int BW = 22
) (
    input  wire logic                 i_clk,
    input  wire logic signed [AW-1:0] i_a,
    input  wire logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0]   o_prod
);

    logic signed [AW+BW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (AW+BW)'(i_a) * (AW+BW)'(i_b);
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

@@ rtl/heat_diffusion_lava_texture.sv @@
`default_nettype none
// Each accepted request reads the heat maps through the single-port memories, then
// computes its pixel in a sequence of steps on the shared multiplier.
// The input is ready only when idle: no new request until the pixel is taken at the output.
// Reset: synchronous, active low. After reset the block clears all heat maps,
// each of (2^floor(log2(MAX_EDGE)))^2 entries, one entry per cycle, before the first request.
module heat_diffusion_lava_texture import hdlt_pkg::*; #(
    parameter int MAX_EDGE      = 64,
    parameter int FRACTION_BITS = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [23:0] i_random_draw,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [7:0]  o_red,
    output logic      [7:0]  o_green,
    output logic      [7:0]  o_blue,
    output logic      [5:0]  o_pixel_x,
    output logic      [5:0]  o_pixel_y,
    output logic             o_frame_end
);

    localparam int LW   = $clog2(MAX_EDGE + 1) - 1;
    localparam int AW   = 2 * LW;
    localparam int F    = FRACTION_BITS;
    localparam int MA_W = 36;
    localparam int MB_W = F + 2;
    localparam int PW   = MA_W + MB_W;
    localparam longint ONE_L = longint'(1) << F;
    localparam logic [2:0] SIZE_MAX = 3'(LW);
    localparam logic signed [MB_W-1:0] K_C01   = MB_W'((ONE_L + 5) / 10);
    localparam logic signed [MB_W-1:0] K_C02   = MB_W'((2 * ONE_L + 5) / 10);
    localparam logic signed [MB_W-1:0] K_ONE   = MB_W'(ONE_L);
    localparam logic signed [MB_W-1:0] K_100   = MB_W'(100);
    localparam logic signed [MB_W-1:0] K_255   = MB_W'(255);
    localparam logic signed [MB_W-1:0] K_128   = MB_W'(128);
    localparam logic signed [32:0]     K_DECAY = 33'((6 * ONE_L + 5000) / 10000);
    localparam logic signed [31:0]     K_RESEED = 32'((15 * ONE_L + 500) / 1000);

    t_state r_state, n_state;

    logic [2:0]    r_size;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_i;
    logic [LW-1:0] r_x, r_y;
    logic          r_last;
    logic [23:0]   r_draw;
    logic [3:0]    r_k;
    logic signed [MA_W-1:0] r_sum9, r_sum4;
    logic signed [31:0]     r_pot_i, r_flame_i;
    logic signed [SUM_W-1:0] r_part;
    logic signed [MB_W-1:0] r_col, r_c2, r_c4;
    logic [7:0] r_red, r_green, r_blue;

    // Size and position decode.
    logic [2:0]    sh;
    logic [LW-1:0] mask;
    logic [AW:0]   total;
    logic [AW-1:0] start_i;
    logic          cfg_wr;

    always_comb begin
        if (r_size < SIZE_MIN) begin
            sh = SIZE_MIN;
        end else if (r_size > SIZE_MAX) begin
            sh = SIZE_MAX;
        end else begin
            sh = r_size;
        end
        mask    = LW'((1 << sh) - 1);
        total   = (AW+1)'(1) << (2 * sh);
        start_i = ((AW+1)'(r_pos) >= total) ? '0 : r_pos;
    end

    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SIZE) ? {29'd0, r_size} : 32'd0;

    // Read address for the current slot.
    logic [LW-1:0] xx, yy, rx, ry, x1, y1;
    logic [1:0]    dx, dy;
    logic [AW-1:0] rd_addr;

    always_comb begin
        xx = r_x + LW'(wobble(r_y[3:0]));
        yy = r_y + LW'(wobble(r_x[3:0]));
        x1 = (r_x + LW'(1)) & mask;
        y1 = (r_y + LW'(1)) & mask;
        dy = (r_k >= 4'd6) ? 2'd2 : ((r_k >= 4'd3) ? 2'd1 : 2'd0);
        dx = 2'(r_k - 4'(3 * dy));
        rx = (xx + LW'(dx) - LW'(1)) & mask;
        ry = (yy + LW'(dy) - LW'(1)) & mask;
        case (r_k)
            4'd9:    begin rx = r_x; ry = r_y; end
            4'd10:   begin rx = x1;  ry = r_y; end
            4'd11:   begin rx = r_x; ry = y1;  end
            4'd12:   begin rx = x1;  ry = y1;  end
            4'd13:   begin rx = r_x; ry = r_y; end
            default: ;
        endcase
        rd_addr = (AW'(ry) << sh) | AW'(rx);
    end

    // Memories share one address.
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [31:0]   soup_w, pot_w, flame_w;
    logic [31:0]   soup_q, pot_q, flame_q;

    hdlt_mem #(.AW(AW), .DW(32)) u_soup (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr), .i_wdata(soup_w), .o_rdata(soup_q)
    );
    hdlt_mem #(.AW(AW), .DW(32)) u_pot (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr), .i_wdata(pot_w), .o_rdata(pot_q)
    );
    hdlt_mem #(.AW(AW), .DW(32)) u_flame (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr), .i_wdata(flame_w), .o_rdata(flame_q)
    );

    // Shared multiplier.
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   prod_sh;

    hdlt_mul #(.AW(MA_W), .BW(MB_W)) u_mul (
        .i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_prod(prod)
    );

    assign prod_sh = prod >>> F;

    // Pixel update values.
    logic signed [SUM_W-1:0] soup_sum;
    logic signed [31:0]      soup_new, pot_new, flame_new;
    logic signed [32:0]      pot_sum, flame_dec;
    logic signed [33:0]      soup2;
    logic signed [MB_W-1:0]  col_new;

    always_comb begin
        soup_sum  = r_part + prod_sh[SUM_W-1:0];
        soup_new  = sat32(soup_sum);
        pot_sum   = 33'(r_pot_i) + 33'(r_flame_i);
        pot_new   = (pot_sum < 0) ? 32'sd0 : sat32(SUM_W'(pot_sum));
        flame_dec = 33'(r_flame_i) - K_DECAY;
        if (r_draw <= DRAW_LIMIT) begin
            flame_new = K_RESEED;
        end else if (flame_dec < -33'(K_ONE)) begin
            flame_new = -32'(K_ONE);
        end else begin
            flame_new = flame_dec[31:0];
        end
        soup2 = 34'(soup_new) <<< 1;
        if (soup2 < 0) begin
            col_new = '0;
        end else if (soup2 > 34'(K_ONE)) begin
            col_new = K_ONE;
        end else begin
            col_new = soup2[MB_W-1:0];
        end
    end

    always_comb begin
        mem_addr = rd_addr;
        mem_we   = 1'b0;
        soup_w   = soup_new;
        pot_w    = pot_new;
        flame_w  = flame_new;
        mul_a    = r_sum9;
        mul_b    = K_C01;
        case (r_state)
            S_CLEAR: begin
                mem_addr = r_clr;
                mem_we   = 1'b1;
                soup_w   = '0;
                pot_w    = '0;
                flame_w  = '0;
            end
            S_SOUP: begin
                mem_addr = r_i;
                mem_we   = 1'b1;
            end
            S_MS4:   begin mul_a = r_sum4;        mul_b = K_C02; end
            S_MR:    begin mul_a = MA_W'(r_col);  mul_b = K_100; end
            S_MC2:   begin mul_a = MA_W'(r_col);  mul_b = r_col; end
            S_MG:    begin mul_a = MA_W'(r_c2);   mul_b = K_255; end
            S_MC4:   begin mul_a = MA_W'(r_c2);   mul_b = r_c2;  end
            S_MB:    begin mul_a = MA_W'(r_c4);   mul_b = K_128; end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_READ;
            S_READ:  if (r_k == K_END) n_state = S_MS9;
            S_MS9:   n_state = S_MS4;
            S_MS4:   n_state = S_SOUP;
            S_SOUP:  n_state = S_MR;
            S_MR:    n_state = S_MC2;
            S_MC2:   n_state = S_C2;
            S_C2:    n_state = S_MG;
            S_MG:    n_state = S_MC4;
            S_MC4:   n_state = S_C4;
            S_C4:    n_state = S_MB;
            S_MB:    n_state = S_BLUE;
            S_BLUE:  n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_size  <= SIZE_RESET;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (cfg_wr && paddr[2] == REG_SIZE) begin
                r_size <= pwdata[2:0];
                r_pos  <= '0;
            end else if (r_state == S_IDLE && i_valid) begin
                r_pos <= ((AW+1)'(start_i) + (AW+1)'(1) == total) ? '0 : start_i + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_i    <= start_i;
                r_x    <= start_i[LW-1:0] & mask;
                r_y    <= LW'(start_i >> sh);
                r_last <= ((AW+1)'(start_i) + (AW+1)'(1) == total);
                r_draw <= i_random_draw;
                r_k    <= '0;
                r_sum9 <= '0;
                r_sum4 <= '0;
            end
            S_READ: begin
                r_k <= r_k + 4'd1;
                // Data of the previous slot arrives now.
                if (r_k != 4'd0) begin
                    if (r_k <= K_POT_FIRST) begin
                        r_sum9 <= r_sum9 + MA_W'($signed(soup_q));
                    end else if (r_k <= K_FLAME) begin
                        r_sum4 <= r_sum4 + MA_W'($signed(pot_q));
                    end else begin
                        r_flame_i <= $signed(flame_q);
                    end
                    if (r_k == K_POT_FIRST + 4'd1) begin
                        r_pot_i <= $signed(pot_q);
                    end
                end
            end
            S_MS4:  r_part  <= prod_sh[SUM_W-1:0];
            S_SOUP: r_col   <= col_new;
            S_MC2:  r_red   <= prod_sh[7:0] + RED_BASE;
            S_C2:   r_c2    <= prod_sh[MB_W-1:0];
            S_MC4:  r_green <= prod_sh[7:0];
            S_C4:   r_c4    <= prod_sh[MB_W-1:0];
            S_BLUE: r_blue  <= prod_sh[7:0];
            default: ;
        endcase
    end

    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_pixel_x   = 6'(r_x);
    assign o_pixel_y   = 6'(r_y);
    assign o_frame_end = r_last;

endmodule
`default_nettype wire
